// ===== hdl/sch_pkg.sv =====
// Shared types and constants for the shape context histogram block.
// No dependencies.
`default_nettype none
package sch_pkg;
	localparam int MAX_ANGLES = 16;
	localparam int MAX_RINGS = 3;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int HIST_DEPTH = MAX_ANGLES * MAX_RINGS;
	localparam int BIN_W = 6;
	localparam int IT_W = 5;
	localparam int CW = 28;
	localparam int ZW = 34;

	typedef enum logic [2:0] {
		REG_NUM_ANGLES = 3'd0,
		REG_NUM_RINGS = 3'd1,
		REG_RADIUS_0 = 3'd2,
		REG_RADIUS_1 = 3'd3,
		REG_RADIUS_2 = 3'd4,
		REG_CENTER_X = 3'd5,
		REG_CENTER_Y = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
		logic count;
		logic dump_start;
		logic dump_step;
	} sch_cmd_t;

	typedef struct packed {
		logic iter_done;
		logic dump_done;
		logic no_bins;
	} sch_sts_t;

	function automatic logic [ZW-1:0] atan_lut(input logic [IT_W-1:0] i);
		logic [ZW-1:0] v;
		case (i)
			5'd0: v = 34'd536870912;
			5'd1: v = 34'd316933406;
			5'd2: v = 34'd167458907;
			5'd3: v = 34'd85004756;
			5'd4: v = 34'd42667331;
			5'd5: v = 34'd21354465;
			5'd6: v = 34'd10679838;
			5'd7: v = 34'd5340245;
			5'd8: v = 34'd2670163;
			5'd9: v = 34'd1335087;
			5'd10: v = 34'd667544;
			5'd11: v = 34'd333772;
			5'd12: v = 34'd166886;
			5'd13: v = 34'd83443;
			5'd14: v = 34'd41722;
			5'd15: v = 34'd20861;
			5'd16: v = 34'd10430;
			5'd17: v = 34'd5215;
			5'd18: v = 34'd2608;
			5'd19: v = 34'd1304;
			5'd20: v = 34'd652;
			5'd21: v = 34'd326;
			5'd22: v = 34'd163;
			5'd23: v = 34'd81;
			default: v = '0;
		endcase
		return v;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/sch_if.sv =====
// Valid/ready channel interfaces for points and results.
// Plain interfaces, no package dependency.
`default_nettype none
interface sch_point_if;
	logic valid;
	logic ready;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic last_point;
	modport source (output valid, point_x, point_y, last_point, input ready);
	modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface sch_result_if;
	logic valid;
	logic ready;
	logic result_kind;
	logic [5:0] bin_index;
	logic bin_valid;
	logic [15:0] bin_count;
	logic last_result;
	modport source (output valid, result_kind, bin_index, bin_valid, bin_count,
		last_result, input ready);
	modport sink (input valid, result_kind, bin_index, bin_valid, bin_count,
		last_result, output ready);
endinterface
`default_nettype wire

// ===== hdl/sch_ctrl.sv =====
// Controller state machine: sequences CORDIC, count update, result and dump.
// Depends on sch_pkg.
`default_nettype none
module sch_ctrl
	import sch_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_last,
	output logic out_valid,
	input wire logic out_ready,
	output logic out_dump,
	output sch_cmd_t cmd,
	input wire sch_sts_t sts
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ITER = 6'b000010,
		S_FIN = 6'b000100,
		S_CNT = 6'b001000,
		S_PRES = 6'b010000,
		S_DUMP = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic last_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_PRES) || (state_q == S_DUMP);
	assign out_dump = (state_q == S_DUMP);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_ITER;
				end
			end
			S_ITER: begin
				cmd.step = 1'b1;
				if (sts.iter_done) state_d = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_CNT;
			end
			S_CNT: begin
				cmd.count = 1'b1;
				state_d = S_PRES;
			end
			S_PRES: begin
				if (out_ready) begin
					if (last_q) begin
						cmd.dump_start = 1'b1;
						state_d = sts.no_bins ? S_IDLE : S_DUMP;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DUMP: begin
				if (out_ready) begin
					cmd.dump_step = 1'b1;
					if (sts.dump_done) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold state and last flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) last_q <= in_last;
		end
	end
endmodule
`default_nettype wire

// ===== hdl/sch_dp.sv =====
// Datapath: config registers, ring test, CORDIC, sector, histogram counters.
// Depends on sch_pkg.
`default_nettype none
module sch_dp
	import sch_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic signed [15:0] point_x,
	input wire logic signed [15:0] point_y,
	input wire sch_cmd_t cmd,
	output sch_sts_t sts,
	input wire logic out_dump,
	input wire logic in_last,
	output logic result_kind,
	output logic [5:0] bin_index,
	output logic bin_valid,
	output logic [15:0] bin_count,
	output logic last_result
);
	logic [4:0] n_q;
	logic [1:0] rings_q;
	logic [9:0] rad_q [3];
	logic signed [15:0] cx_q, cy_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= 5'd6;
			rings_q <= 2'd1;
			rad_q[0] <= 10'd20;
			rad_q[1] <= 10'd40;
			rad_q[2] <= 10'd80;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_ANGLES: n_q <= cfg_data[4:0];
				REG_NUM_RINGS: rings_q <= cfg_data[1:0];
				REG_RADIUS_0: rad_q[0] <= cfg_data[9:0];
				REG_RADIUS_1: rad_q[1] <= cfg_data[9:0];
				REG_RADIUS_2: rad_q[2] <= cfg_data[9:0];
				REG_CENTER_X: cx_q <= cfg_data;
				REG_CENTER_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective counts
	logic [4:0] n_eff;
	logic [1:0] r_eff;
	logic [5:0] nbins;
	assign n_eff = (n_q == 5'd0) ? 5'd1 : ((n_q > 5'(MAX_ANGLES)) ? 5'(MAX_ANGLES) : n_q);
	assign r_eff = rings_q;
	assign nbins = 6'(r_eff) * 6'(n_eff);
	assign sts.no_bins = (nbins == 6'd0);

	// Point load: offsets, distance, ring
	logic signed [16:0] dx, dy;
	logic [33:0] d2;
	logic [1:0] ring_d;
	logic inring_d;
	assign dx = 17'(point_x) - 17'(cx_q);
	assign dy = 17'(point_y) - 17'(cy_q);
	assign d2 = unsigned'(34'(dx) * 34'(dx)) + unsigned'(34'(dy) * 34'(dy));
	always_comb begin
		ring_d = 2'd0;
		inring_d = 1'b0;
		for (int k = 2; k >= 0; k--) begin
			if (2'(k) < r_eff && d2 < 34'(20'(rad_q[k]) * 20'(rad_q[k]))) begin
				ring_d = 2'(k);
				inring_d = 1'b1;
			end
		end
	end

	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	logic [IT_W-1:0] it_q;
	logic [1:0] ring_q;
	logic zero_q, inring_q, valid_q;
	logic [5:0] bin_q;

	assign sts.iter_done = (it_q == IT_W'(CORDIC_ITERATIONS - 1));

	logic signed [CW-1:0] xs, ys;
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;

	// Sector from angle
	logic signed [ZW-1:0] zr;
	logic signed [15:0] theta;
	logic signed [23:0] a;
	logic [4:0] sec;
	assign zr = z_q + ZW'(32768);
	assign theta = zr[31:16];
	always_comb begin
		a = 24'(2 * $signed({1'b0, n_eff}) * theta) + 24'sd65536;
		if (a < 0) a = a + 24'($signed({1'b0, n_eff}) * 131072);
		sec = a[21:17];
		if (sec > n_eff - 5'd1) sec = n_eff - 5'd1;
	end

	// Bin of the point in work
	logic [5:0] bin_d;
	logic valid_d;
	always_comb begin
		bin_d = '0;
		valid_d = 1'b0;
		if (r_eff == 2'd0) begin
			valid_d = 1'b0;
		end else if (zero_q) begin
			valid_d = 1'b1;
		end else if (inring_q) begin
			valid_d = 1'b1;
			bin_d = 6'(ring_q) * 6'(n_eff) + 6'(sec);
		end
	end

	// CORDIC iterations
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring_q <= ring_d;
			inring_q <= inring_d;
			zero_q <= (dx == 0) && (dy == 0);
			it_q <= '0;
			if (dx < 0) begin
				x_q <= -(CW'(dx) <<< 8);
				y_q <= -(CW'(dy) <<< 8);
				z_q <= ZW'(64'sd2147483648);
			end else begin
				x_q <= CW'(dx) <<< 8;
				y_q <= CW'(dy) <<< 8;
				z_q <= '0;
			end
		end else if (cmd.step) begin
			it_q <= it_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_lut(it_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_lut(it_q);
			end
		end else if (cmd.finish) begin
			valid_q <= valid_d;
			bin_q <= bin_d;
		end
	end

	// Histogram memory with registered read; a flag per entry marks it written
	logic [15:0] hist_mem [HIST_DEPTH];
	logic [HIST_DEPTH-1:0] hvld_q;
	logic [15:0] rd_q;
	logic [5:0] didx_q;
	logic [5:0] cnt_idx;
	logic [5:0] rd_addr;
	logic rd_en;
	logic [15:0] cur_cnt;
	logic clear_all;
	assign cnt_idx = out_dump ? didx_q : bin_q;
	assign sts.dump_done = (didx_q == nbins - 6'd1);
	assign clear_all = (cmd.dump_start && sts.no_bins) || (cmd.dump_step && sts.dump_done);
	assign cur_cnt = hvld_q[bin_q] ? rd_q : 16'd0;

	// Read the point bin at finish, the first entry at dump start, the next per step
	always_comb begin
		rd_en = 1'b0;
		rd_addr = bin_d;
		if (cmd.finish) begin
			rd_en = 1'b1;
		end else if (cmd.dump_start) begin
			rd_en = 1'b1;
			rd_addr = '0;
		end else if (cmd.dump_step && !sts.dump_done) begin
			rd_en = 1'b1;
			rd_addr = didx_q + 6'd1;
		end
	end

	// Memory read and saturating count write
	always_ff @(posedge clk) begin
		if (rd_en) rd_q <= hist_mem[rd_addr];
		if (cmd.count && valid_q && cur_cnt != 16'hFFFF)
			hist_mem[bin_q] <= cur_cnt + 16'd1;
	end

	// Entry flags and dump index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			didx_q <= '0;
			hvld_q <= '0;
		end else begin
			if (cmd.count && valid_q) hvld_q[bin_q] <= 1'b1;
			if (clear_all) hvld_q <= '0;
			if (cmd.dump_start) didx_q <= '0;
			if (cmd.dump_step) didx_q <= didx_q + 6'd1;
		end
	end

	// Output payload
	assign result_kind = out_dump;
	assign bin_index = cnt_idx;
	assign bin_valid = out_dump ? 1'b0 : valid_q;
	assign bin_count = (out_dump && hvld_q[didx_q]) ? rd_q : 16'd0;
	assign last_result = out_dump ? sts.dump_done : (!in_last || sts.no_bins);
endmodule
`default_nettype wire

// ===== hdl/shape_context_histogram.sv =====
// Top level of the shape context histogram: controller plus datapath.
// A point result is valid after the 16 CORDIC steps and the finish and count states.
// A new point is accepted only after the sink has taken the last point's result;
// a last point first dumps every histogram entry, if there are any.
// Reset clears configuration to defaults and all counter flags, so counts read zero.
// Depends on sch_pkg, sch_if, sch_ctrl, sch_dp.
`default_nettype none
module shape_context_histogram
	import sch_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data,
	sch_point_if.sink points,
	sch_result_if.source results
);
	sch_cmd_t cmd;
	sch_sts_t sts;
	logic out_dump;
	logic last_q;

	// Keep last flag of the point in work for the result field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_q <= 1'b0;
		else if (cmd.load) last_q <= points.last_point;
	end

	sch_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(points.valid), .in_ready(points.ready), .in_last(points.last_point),
		.out_valid(results.valid), .out_ready(results.ready), .out_dump(out_dump),
		.cmd(cmd), .sts(sts)
	);

	sch_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.point_x(points.point_x), .point_y(points.point_y),
		.cmd(cmd), .sts(sts), .out_dump(out_dump), .in_last(last_q),
		.result_kind(results.result_kind), .bin_index(results.bin_index),
		.bin_valid(results.bin_valid), .bin_count(results.bin_count),
		.last_result(results.last_result)
	);
endmodule
`default_nettype wire
